@@ rtl/core/pidaw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PID anti-windup package
// Shared widths, register indexes, reset values and operation codes for the PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    // Payload widths
    localparam int unsigned ERR_W   = 16;
    localparam int unsigned DRIVE_W = 16;
    localparam int unsigned ACC_W   = 24;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 23;

    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned LIM_W   = 23;
    localparam int unsigned POWER_W = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATE_BELOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER       = 3'd6;

    // Reset values
    localparam logic [GAIN_W-1:0]  RST_GAIN_P          = 16'd256;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I          = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D          = 16'd0;
    localparam logic [THR_W-1:0]   RST_INTEGRATE_BELOW = 16'd32768;
    localparam logic [LIM_W-1:0]   RST_WINDUP_LIMIT    = 23'd8388607;
    localparam logic [POWER_W-1:0] RST_MAX_POWER       = 15'd25600;
    localparam logic [POWER_W-1:0] RST_MIN_POWER       = 15'd0;

    // Operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

endpackage : pidaw_pkg
`default_nettype wire

@@ rtl/core/pidaw_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PID anti-windup input channel
// Valid/ready channel carrying one error sample and its operation code.
// ----------------------------------------------------------------------------
interface pidaw_in_if;
    import pidaw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [ERR_W-1:0] error_in;

    modport source (output valid, output op, output error_in, input ready);
    modport sink   (input valid, input op, input error_in, output ready);

endinterface : pidaw_in_if
`default_nettype wire

@@ rtl/core/pidaw_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PID anti-windup output channel
// Valid/ready channel carrying one drive value.
// ----------------------------------------------------------------------------
interface pidaw_out_if;
    import pidaw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);

endinterface : pidaw_out_if
`default_nettype wire

@@ rtl/core/pid_controller_antiwindup_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Fixed-point PID step with integral threshold, windup clamp, sign-change
// reset and output ceiling/floor; two-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
// The unit accepts one beat per clock while the output is not stalled and
// returns one drive beat for each input beat. A beat is registered in stage
// one and then in the output register, where it waits until the sink takes it.
// Stage one is loaded straight from the input beat: the three gain products
// (P on the error, I on the integral as it stood before this beat, D on the
// error difference) are formed and registered, and the integral and previous
// error are updated in the same edge, so the next beat may follow at once.
// That state loop (threshold compare, add, windup clamp, sign-change clear)
// sets the one-beat-per-cycle rate. Stage two adds the terms, saturates to
// +/- max_power and applies the min_power floor (zero goes positive) into the
// output register. A clear beat zeroes the state and returns a drive of zero.
// The output register parts the two sides: a new beat is taken while a
// finished result waits, as long as stage one is empty. Products are
// truncated by an arithmetic shift of FRAC_BITS. Write configuration only
// while the unit is idle; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    pidaw_in_if.sink                             i_in,
    pidaw_out_if.source                          o_out,
    input  wire                                  i_cfg_we,
    input  wire [pidaw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [pidaw_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import pidaw_pkg::*;

    // Product widths: unsigned gain (as signed) times signed operand
    localparam int unsigned PT_W  = GAIN_W + 1 + ERR_W;
    localparam int unsigned DT_W  = GAIN_W + 1 + ERR_W + 1;
    localparam int unsigned IT_W  = GAIN_W + 1 + ACC_W;
    localparam int unsigned SUM_W = IT_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic [GAIN_W-1:0]  r_gain_d;
    logic [THR_W-1:0]   r_int_below;
    logic [LIM_W-1:0]   r_windup_lim;
    logic [POWER_W-1:0] r_max_power;
    logic [POWER_W-1:0] r_min_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= RST_GAIN_P;
            r_gain_i     <= RST_GAIN_I;
            r_gain_d     <= RST_GAIN_D;
            r_int_below  <= RST_INTEGRATE_BELOW;
            r_windup_lim <= RST_WINDUP_LIMIT;
            r_max_power  <= RST_MAX_POWER;
            r_min_power  <= RST_MIN_POWER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:          r_gain_p     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:          r_gain_i     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:          r_gain_d     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEGRATE_BELOW: r_int_below  <= i_cfg_wdata[THR_W-1:0];
                CFG_WINDUP_LIMIT:    r_windup_lim <= i_cfg_wdata[LIM_W-1:0];
                CFG_MAX_POWER:       r_max_power  <= i_cfg_wdata[POWER_W-1:0];
                CFG_MIN_POWER:       r_min_power  <= i_cfg_wdata[POWER_W-1:0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: advance the output register when empty or being taken,
    // and take a new beat whenever stage one is empty or moves on.
    // ------------------------------------------------------------------
    logic r_s1_vld;
    logic r_out_vld;
    logic w_adv;
    logic w_in_rdy;
    logic w_in_acc;

    assign w_adv    = !r_out_vld || o_out.ready;
    assign w_in_rdy = !r_s1_vld || w_adv;
    assign w_in_acc = i_in.valid && w_in_rdy;

    assign i_in.ready  = w_in_rdy;
    assign o_out.valid = r_out_vld;

    // ------------------------------------------------------------------
    // Stage one: products from the incoming beat and current state
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ERR_W-1:0] r_last_err;

    logic signed [ERR_W-1:0] w_err;
    logic signed [ERR_W:0]   w_err_x;
    logic signed [ERR_W:0]   w_ediff;
    logic signed [GAIN_W:0]  w_gp;
    logic signed [GAIN_W:0]  w_gi;
    logic signed [GAIN_W:0]  w_gd;
    logic signed [PT_W-1:0]  w_pt;
    logic signed [IT_W-1:0]  w_it;
    logic signed [DT_W-1:0]  w_dt;

    assign w_err   = i_in.error_in;
    assign w_err_x = {w_err[ERR_W-1], w_err};
    assign w_ediff = w_err_x - $signed({r_last_err[ERR_W-1], r_last_err});
    assign w_gp    = $signed({1'b0, r_gain_p});
    assign w_gi    = $signed({1'b0, r_gain_i});
    assign w_gd    = $signed({1'b0, r_gain_d});

    assign w_pt = (PT_W'(w_gp) * PT_W'(w_err)) >>> FRAC_BITS;
    assign w_it = (IT_W'(w_gi) * IT_W'(r_acc)) >>> FRAC_BITS;
    assign w_dt = (DT_W'(w_gd) * DT_W'(w_ediff)) >>> FRAC_BITS;

    // Integral update: threshold, add, windup clamp, sign-change clear
    logic [ERR_W:0]          w_err_mag;
    logic                    w_integrate;
    logic signed [ACC_W:0]   w_acc_sum;
    logic signed [ACC_W:0]   w_lim;
    logic signed [ACC_W:0]   w_acc_clamp;
    logic                    w_err_pos;
    logic                    w_err_neg;
    logic                    w_last_pos;
    logic                    w_last_neg;
    logic                    w_flip;
    logic signed [ACC_W-1:0] n_acc;

    assign w_err_mag   = w_err[ERR_W-1] ? unsigned'(-w_err_x) : unsigned'(w_err_x);
    assign w_integrate = w_err_mag < {1'b0, r_int_below};
    assign w_acc_sum   = $signed({r_acc[ACC_W-1], r_acc})
                       + (w_integrate ? (ACC_W+1)'(w_err) : '0);
    assign w_lim       = $signed({2'b00, r_windup_lim});

    always_comb begin
        priority if (w_acc_sum > w_lim) begin
            w_acc_clamp = w_lim;
        end else if (w_acc_sum < -w_lim) begin
            w_acc_clamp = -w_lim;
        end else begin
            w_acc_clamp = w_acc_sum;
        end
    end

    assign w_err_pos  = !w_err[ERR_W-1] && (w_err != '0);
    assign w_err_neg  = w_err[ERR_W-1];
    assign w_last_pos = !r_last_err[ERR_W-1] && (r_last_err != '0);
    assign w_last_neg = r_last_err[ERR_W-1];
    assign w_flip     = (w_err_pos && w_last_neg) || (w_err_neg && w_last_pos);
    assign n_acc      = w_flip ? '0 : w_acc_clamp[ACC_W-1:0];

    // Hold state across idle cycles; update or clear on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_last_err <= '0;
        end else if (w_in_acc) begin
            if (i_in.op == OP_CLEAR) begin
                r_acc      <= '0;
                r_last_err <= '0;
            end else begin
                r_acc      <= n_acc;
                r_last_err <= w_err;
            end
        end
    end

    logic                   r_s1_clr;
    logic signed [PT_W-1:0] r_pt;
    logic signed [IT_W-1:0] r_it;
    logic signed [DT_W-1:0] r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_rdy) begin
            r_s1_vld <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_clr <= (i_in.op == OP_CLEAR);
            r_pt     <= w_pt;
            r_it     <= w_it;
            r_dt     <= w_dt;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: sum, ceiling, floor
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_maxp;
    logic signed [SUM_W-1:0]   w_sat;
    logic signed [DRIVE_W-1:0] w_sat_n;
    logic [DRIVE_W-1:0]        w_sat_mag;
    logic signed [DRIVE_W-1:0] w_minp;
    logic signed [DRIVE_W-1:0] n_drive;

    assign w_sum  = SUM_W'(r_pt) + SUM_W'(r_it) + SUM_W'(r_dt);
    assign w_maxp = $signed(SUM_W'({1'b0, r_max_power}));

    always_comb begin
        priority if (w_sum > w_maxp) begin
            w_sat = w_maxp;
        end else if (w_sum < -w_maxp) begin
            w_sat = -w_maxp;
        end else begin
            w_sat = w_sum;
        end
    end

    assign w_sat_n   = w_sat[DRIVE_W-1:0];
    assign w_sat_mag = w_sat_n[DRIVE_W-1] ? unsigned'(-w_sat_n) : unsigned'(w_sat_n);
    assign w_minp    = $signed({1'b0, r_min_power});

    always_comb begin
        priority if (r_s1_clr) begin
            n_drive = '0;
        end else if ((r_min_power != '0) && (w_sat_mag < {1'b0, r_min_power})) begin
            // raise small magnitudes to the floor; zero goes positive
            n_drive = w_sat_n[DRIVE_W-1] ? -w_minp : w_minp;
        end else begin
            n_drive = w_sat_n;
        end
    end

    logic signed [DRIVE_W-1:0] r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_vld) begin
            r_drive <= n_drive;
        end
    end

    assign o_out.drive = r_drive;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in.op == OP_CLEAR) |=> (r_acc == '0) && (r_last_err == '0))
        else $error("clear beat did not zero the integral state");

    a_acc_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ($signed({r_acc[ACC_W-1], r_acc}) <= w_lim)
                  && ($signed({r_acc[ACC_W-1], r_acc}) >= -w_lim))
        else $error("integral outside windup limit after update");

    a_drive_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_min_power == '0)
            |-> ($signed({r_drive[DRIVE_W-1], r_drive}) <= $signed({2'b00, r_max_power}))
             && ($signed({r_drive[DRIVE_W-1], r_drive}) >= -$signed({2'b00, r_max_power})))
        else $error("drive exceeds max_power");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_adv |=> r_s1_vld && $stable(r_pt) && $stable(r_it) && $stable(r_dt))
        else $error("stage one lost a beat while the output stalled");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_out_vld && !o_out.ready |-> !i_in.ready)
        else $error("input ready while both stages are full and stalled");

endmodule : pid_controller_antiwindup_unit
`default_nettype wire
